FILE: src/ajb_pkg.sv
// shared types, constants and state codes for the audio jitter buffer
package ajb_pkg;

   localparam int DEPTH_LIMIT_DEF  = 8;
   localparam int PAYLOAD_BITS_DEF = 16;

   localparam int SEQ_W       = 32;
   localparam int CHUNK_PAY_W = 16;
   localparam int IDLE_W      = 16;
   localparam int FILL_W      = 4;

   localparam int REQ_DATA_W = 48;
   localparam int RSP_PAD_W  = 4;
   localparam int RSP_DATA_W = 72;

   localparam logic [IDLE_W-1:0] IDLE_MAX = '1;

   typedef enum logic {
      ACT_PUSH = 1'b0,
      ACT_PULL = 1'b1
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DROP,
      ST_WRITE,
      ST_FETCH,
      ST_CHECK,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic                   has_chunk;
      logic [SEQ_W-1:0]       out_seq;
      logic [CHUNK_PAY_W-1:0] out_payload;
      logic [IDLE_W-1:0]      idle_count;
      logic [FILL_W-1:0]      fill_level;
   } rsp_type;

endpackage

FILE: src/ajb_ram.sv
// generic single write port ram with registered read
module ajb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/ajb_ctrl.sv
// sequencer, buffer pointers, sequence compare unit and result register
module ajb_ctrl
   import ajb_pkg::*;
#(
   parameter int DEPTH_LIMIT  = DEPTH_LIMIT_DEF,
   parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF,
   localparam int SIZE    = DEPTH_LIMIT + 1,
   localparam int IDX_W   = $clog2(SIZE),
   localparam int STORE_W = (PAYLOAD_BITS < CHUNK_PAY_W) ? PAYLOAD_BITS : CHUNK_PAY_W,
   localparam int ENTRY_W = SEQ_W + STORE_W
) (
   input  logic                   clock,
   input  logic                   reset,
   // request side
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_action,
   input  logic [SEQ_W-1:0]       req_seq,
   input  logic [CHUNK_PAY_W-1:0] req_payload,
   // result side
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp,
   // entry store
   output logic                   ram_wr_en,
   output logic [IDX_W-1:0]       ram_wr_addr,
   output logic [ENTRY_W-1:0]     ram_wr_data,
   output logic                   ram_rd_en,
   output logic [IDX_W-1:0]       ram_rd_addr,
   input  logic [ENTRY_W-1:0]     ram_rd_data
);

   localparam int CNT_W  = $clog2(SIZE + 1);
   localparam int SUM_W  = CNT_W + 1;
   localparam int WARM_W = $clog2(DEPTH_LIMIT + 1);

   state_type               state_ff, state_in;
   logic [IDX_W-1:0]        head_ff, head_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [SEQ_W-1:0]        exp_ff, exp_in;
   logic [WARM_W-1:0]       warm_ff, warm_in;
   logic [IDLE_W-1:0]       idle_ff, idle_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff, rsp_in;
   logic                    res_has_ff, res_has_in;
   logic [SEQ_W-1:0]        res_seq_ff, res_seq_in;
   logic [STORE_W-1:0]      res_pay_ff, res_pay_in;
   logic [SEQ_W-1:0]        req_seq_ff, req_seq_in;
   logic [STORE_W-1:0]      req_pay_ff, req_pay_in;

   logic [IDX_W-1:0]        head_next;
   logic [SUM_W-1:0]        tail_sum;
   logic [SUM_W-1:0]        tail_wrap;
   logic [IDLE_W-1:0]       idle_inc;
   logic [SEQ_W-1:0]        head_seq;
   logic [STORE_W-1:0]      head_pay;
   logic                    seq_match;
   logic                    seq_below;

   // head pointer advance with wrap
   assign head_next = (head_ff == IDX_W'(SIZE - 1)) ? '0 : head_ff + 1'b1;

   // tail slot: head + count stays below twice the store size
   assign tail_sum  = SUM_W'(head_ff) + SUM_W'(count_ff);
   assign tail_wrap = (tail_sum >= SUM_W'(SIZE)) ? tail_sum - SUM_W'(SIZE) : tail_sum;

   assign idle_inc = (idle_ff == IDLE_MAX) ? idle_ff : idle_ff + 1'b1;

   // shared sequence compare against the expected number
   assign head_seq  = ram_rd_data[SEQ_W-1:0];
   assign head_pay  = ram_rd_data[ENTRY_W-1:SEQ_W];
   assign seq_match = (exp_ff == '0) || (head_seq == exp_ff);
   assign seq_below = head_seq < exp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         exp_ff       <= '0;
         warm_ff      <= '0;
         idle_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         exp_ff       <= exp_in;
         warm_ff      <= warm_in;
         idle_ff      <= idle_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff     <= rsp_in;
      res_has_ff <= res_has_in;
      res_seq_ff <= res_seq_in;
      res_pay_ff <= res_pay_in;
      req_seq_ff <= req_seq_in;
      req_pay_ff <= req_pay_in;
   end

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      exp_in       = exp_ff;
      warm_in      = warm_ff;
      idle_in      = idle_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      res_has_in   = res_has_ff;
      res_seq_in   = res_seq_ff;
      res_pay_in   = res_pay_ff;
      req_seq_in   = req_seq_ff;
      req_pay_in   = req_pay_ff;
      req_ready    = 1'b0;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = tail_wrap[IDX_W-1:0];
      ram_wr_data  = {req_pay_ff, req_seq_ff};
      ram_rd_en    = 1'b0;
      ram_rd_addr  = head_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               req_seq_in = req_seq;
               req_pay_in = req_payload[STORE_W-1:0];
               res_has_in = 1'b0;
               res_seq_in = '0;
               res_pay_in = '0;
               if (req_action == ACT_PUSH) begin
                  state_in = ST_DROP;
               end else if (warm_ff < WARM_W'(DEPTH_LIMIT)) begin
                  // slow start answers empty without touching idle
                  warm_in  = warm_ff + 1'b1;
                  state_in = ST_RESP;
               end else if (count_ff == '0) begin
                  idle_in  = idle_inc;
                  state_in = ST_RESP;
               end else begin
                  state_in = ST_FETCH;
               end
            end
         end
         ST_DROP: begin
            // overfull store loses its oldest entry before the push
            if (count_ff > CNT_W'(DEPTH_LIMIT)) begin
               head_in  = head_next;
               count_in = count_ff - 1'b1;
               exp_in   = exp_ff + 1'b1;
            end
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            ram_wr_en = 1'b1;
            count_in  = count_ff + 1'b1;
            state_in  = ST_RESP;
         end
         ST_FETCH: begin
            ram_rd_en = 1'b1;
            state_in  = ST_CHECK;
         end
         ST_CHECK: begin
            priority if (seq_match) begin
               head_in    = head_next;
               count_in   = count_ff - 1'b1;
               exp_in     = head_seq + 1'b1;
               idle_in    = '0;
               res_has_in = 1'b1;
               res_seq_in = head_seq;
               res_pay_in = head_pay;
               state_in   = ST_RESP;
            end else if (seq_below) begin
               // stale entry, discard it and look at the next one if any remain
               head_in  = head_next;
               count_in = count_ff - 1'b1;
               if (count_ff == CNT_W'(1)) begin
                  idle_in  = idle_inc;
                  state_in = ST_RESP;
               end else begin
                  state_in = ST_FETCH;
               end
            end else begin
               // gap in the numbers
               exp_in   = exp_ff + 1'b1;
               idle_in  = idle_inc;
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in       = 1'b1;
               rsp_in.has_chunk   = res_has_ff;
               rsp_in.out_seq     = res_seq_ff;
               rsp_in.out_payload = CHUNK_PAY_W'(res_pay_ff);
               rsp_in.idle_count  = idle_ff;
               rsp_in.fill_level  = FILL_W'(count_ff);
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

FILE: src/audio_jitter_buffer.sv
// top level of the audio jitter buffer: stream ports, sequencer and entry store
//
//  channel | direction | handshake             | contents
//  --------+-----------+-----------------------+---------------------------------------------
//  req     | in        | req_tvalid/req_tready | tuser: action; tdata: chunk_seq, chunk_payload
//  rsp     | out       | rsp_tvalid/rsp_tready | tuser: has_chunk; tdata: seq, payload, idle, fill
//
//  a push goes from accept to the next ready through drop check, store write and result
//  a pull in slow start or on an empty buffer goes straight to the result
//  a pull on a filled buffer examines entries one after another; each examined entry
//  costs a store read (registered read port) and a compare before the result
//  reset clears pointers, fill count, expected number, slow start and idle counters;
//  the entry store itself is not cleared
//  a request is taken while the previous result still waits; the sequencer holds its
//  result until the output register is free
module audio_jitter_buffer
   import ajb_pkg::*;
#(
   parameter int DEPTH_LIMIT  = DEPTH_LIMIT_DEF,
   parameter int PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic                  req_tuser,   // [0] action
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [31:0] chunk_seq, [47:32] chunk_payload
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic                  rsp_tuser,   // [0] has_chunk
   output logic [RSP_DATA_W-1:0] rsp_tdata    // [31:0] out_seq, [47:32] out_payload,
                                              // [63:48] idle_count, [67:64] fill_level
);

   // store geometry: one slot beyond the depth limit
   localparam int SIZE    = DEPTH_LIMIT + 1;
   localparam int IDX_W   = $clog2(SIZE);
   localparam int STORE_W = (PAYLOAD_BITS < CHUNK_PAY_W) ? PAYLOAD_BITS : CHUNK_PAY_W;
   localparam int ENTRY_W = SEQ_W + STORE_W;

   rsp_type              rsp;
   logic                 ram_wr_en;
   logic [IDX_W-1:0]     ram_wr_addr;
   logic [ENTRY_W-1:0]   ram_wr_data;
   logic                 ram_rd_en;
   logic [IDX_W-1:0]     ram_rd_addr;
   logic [ENTRY_W-1:0]   ram_rd_data;

   // sequencer with the expected-number compare unit
   ajb_ctrl #(
      .DEPTH_LIMIT  (DEPTH_LIMIT),
      .PAYLOAD_BITS (PAYLOAD_BITS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_action  (req_tuser),
      .req_seq     (req_tdata[SEQ_W-1:0]),
      .req_payload (req_tdata[SEQ_W+CHUNK_PAY_W-1:SEQ_W]),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp         (rsp),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

   // circular chunk store, sequence number in the low bits
   ajb_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SIZE)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // result packing, zero padded to whole bytes
   assign rsp_tuser = rsp.has_chunk;
   assign rsp_tdata = {{RSP_PAD_W{1'b0}}, rsp.fill_level, rsp.idle_count,
                       rsp.out_payload, rsp.out_seq};

endmodule

FILE: tb/tb_audio_jitter_buffer.sv
// self-checking testbench for the audio jitter buffer: directed table and random playout
`timescale 1ns / 1ps

module tb_audio_jitter_buffer;
   import ajb_pkg::*;

   localparam int STORE_N          = DEPTH_LIMIT_DEF + 1;
   localparam int DIRECTED_N       = 22;
   localparam int RANDOM_PER_PHASE = 405;
   localparam int OWED_N           = 16;      // ring of responses still owed

   // one row of the directed table; want is used only where pinned is set
   typedef struct packed {
      action_type             act;
      logic [SEQ_W-1:0]       seq;
      logic [CHUNK_PAY_W-1:0] pay;
      logic                   pinned;
      rsp_type                want;
   } stim_row_type;

   // directed requests: corner values, slow start, wrap of the expected number,
   // empty pulls, a gap that is waited out, and stale entries discarded on pull
   localparam stim_row_type DIRECTED [DIRECTED_N] = '{
      // pushes right after reset, extremes of both fields
      '{ACT_PUSH, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, {1'b0, 32'h0, 16'h0, 16'd0, 4'd1}},
      '{ACT_PUSH, 32'h0000_0000, 16'h0000, 1'b1, {1'b0, 32'h0, 16'h0, 16'd0, 4'd2}},
      // slow start: the first pulls answer empty and leave the idle counter alone
      '{ACT_PULL, 32'h0, 16'h0, 1'b1, {1'b0, 32'h0, 16'h0, 16'd0, 4'd2}},
      '{ACT_PULL, 32'h0, 16'h0, 1'b1, {1'b0, 32'h0, 16'h0, 16'd0, 4'd2}},
      '{ACT_PULL, 32'h0, 16'h0, 1'b1, {1'b0, 32'h0, 16'h0, 16'd0, 4'd2}},
      '{ACT_PULL, 32'h0, 16'h0, 1'b1, {1'b0, 32'h0, 16'h0, 16'd0, 4'd2}},
      '{ACT_PULL, 32'h0, 16'h0, 1'b1, {1'b0, 32'h0, 16'h0, 16'd0, 4'd2}},
      '{ACT_PULL, 32'h0, 16'h0, 1'b1, {1'b0, 32'h0, 16'h0, 16'd0, 4'd2}},
      '{ACT_PULL, 32'h0, 16'h0, 1'b1, {1'b0, 32'h0, 16'h0, 16'd0, 4'd2}},
      '{ACT_PULL, 32'h0, 16'h0, 1'b1, {1'b0, 32'h0, 16'h0, 16'd0, 4'd2}},
      // expected number zero takes any head; all-ones plus one wraps back to zero
      '{ACT_PULL, 32'h0, 16'h0, 1'b1, {1'b1, 32'hFFFF_FFFF, 16'hFFFF, 16'd0, 4'd1}},
      '{ACT_PULL, 32'h0, 16'h0, 1'b1, {1'b1, 32'h0, 16'h0, 16'd0, 4'd0}},
      // empty buffer after slow start counts as idle
      '{ACT_PULL, 32'h0, 16'h0, 1'b1, {1'b0, 32'h0, 16'h0, 16'd1, 4'd0}},
      // gap ahead of the expected number, then late chunks queued behind it
      '{ACT_PUSH, 32'd5, 16'h1234, 1'b0, '0},
      '{ACT_PULL, 32'h0, 16'h0, 1'b0, '0},
      '{ACT_PUSH, 32'd1, 16'hA5A5, 1'b0, '0},
      '{ACT_PUSH, 32'd3, 16'h5A5A, 1'b0, '0},
      '{ACT_PULL, 32'h0, 16'h0, 1'b0, '0},
      '{ACT_PULL, 32'h0, 16'h0, 1'b0, '0},
      '{ACT_PULL, 32'h0, 16'h0, 1'b0, '0},
      '{ACT_PULL, 32'h0, 16'h0, 1'b0, '0},
      // stale entries are discarded and the pull ends empty
      '{ACT_PULL, 32'h0, 16'h0, 1'b0, '0}
   };

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic                  req_tuser = 1'b0;      // [0] action
   logic [REQ_DATA_W-1:0] req_tdata = '0;        // [31:0] chunk_seq, [47:32] chunk_payload
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic                  rsp_tuser;             // [0] has_chunk
   logic [RSP_DATA_W-1:0] rsp_tdata;             // [31:0] seq, [47:32] payload,
                                                 // [63:48] idle_count, [67:64] fill_level

   // predicted buffer state
   logic [SEQ_W-1:0]       store_seq [STORE_N];
   logic [CHUNK_PAY_W-1:0] store_pay [STORE_N];
   int                     head_ptr   = 0;
   int                     held       = 0;
   int                     warm_pulls = 0;
   logic [SEQ_W-1:0]       play_seq   = '0;
   logic [IDLE_W-1:0]      idle_run   = '0;

   rsp_type owed_rsp [OWED_N];   // responses still owed by the block, oldest at owed_rd
   int      owed_wr      = 0;
   int      owed_rd      = 0;
   int      mismatches   = 0;
   int      send_gap_pct = 0;  // chance per cycle that the sender holds back
   int      stall_pct    = 0;  // chance per cycle that the receiver stalls

   audio_jitter_buffer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

   always #6 clock = ~clock;

   // playout buffer behavior for one accepted request
   function automatic rsp_type predict_playout(input action_type act,
                                               input logic [SEQ_W-1:0] seq,
                                               input logic [CHUNK_PAY_W-1:0] pay);
      rsp_type          r;
      logic [SEQ_W-1:0] head_seq;
      logic             settled;
      r = '0;
      settled = 1'b0;
      if (act == ACT_PUSH) begin
         // overfull: drop oldest down to the limit, expected number follows
         while (held > DEPTH_LIMIT_DEF) begin
            head_ptr = (head_ptr + 1) % STORE_N;
            held--;
            play_seq++;
         end
         store_seq[(head_ptr + held) % STORE_N] = seq;
         store_pay[(head_ptr + held) % STORE_N] = pay;
         held++;
      end else if (warm_pulls < DEPTH_LIMIT_DEF) begin
         warm_pulls++;
      end else begin
         while (held != 0 && !settled) begin
            head_seq = store_seq[head_ptr];
            if (play_seq == '0 || head_seq == play_seq) begin
               r.has_chunk   = 1'b1;
               r.out_seq     = head_seq;
               r.out_payload = store_pay[head_ptr];
               head_ptr = (head_ptr + 1) % STORE_N;
               held--;
               play_seq = head_seq + 1'b1;
               idle_run = '0;
               settled  = 1'b1;
            end else if (head_seq < play_seq) begin
               // stale, plain unsigned compare
               head_ptr = (head_ptr + 1) % STORE_N;
               held--;
            end else begin
               // gap: skip one number and answer empty
               play_seq++;
               settled = 1'b1;
            end
         end
         if (!r.has_chunk && idle_run != IDLE_MAX)
            idle_run++;
      end
      r.idle_count = idle_run;
      r.fill_level = FILL_W'(held);
      return r;
   endfunction

   // offer one request, wait for the handshake, then record what it owes
   task automatic send_request(input action_type act, input logic [SEQ_W-1:0] seq,
                               input logic [CHUNK_PAY_W-1:0] pay, input logic pinned,
                               input rsp_type want);
      rsp_type predicted;
      while ($urandom_range(0, 99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {pay, seq};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      predicted = predict_playout(act, seq, pay);
      owed_rsp[owed_wr % OWED_N] = pinned ? want : predicted;
      owed_wr++;
   endtask

   // receiver back-pressure, redrawn every cycle
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
   end

   // response checker: each accepted response against the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      logic    bad;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (owed_wr == owed_rd) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response: tuser %0b tdata %h", rsp_tuser, rsp_tdata);
         end else begin
            want = owed_rsp[owed_rd % OWED_N];
            owed_rd++;
            bad  = (rsp_tuser !== want.has_chunk)
                || (rsp_tdata[31:0]  !== want.out_seq)
                || (rsp_tdata[47:32] !== want.out_payload)
                || (rsp_tdata[63:48] !== want.idle_count)
                || (rsp_tdata[67:64] !== want.fill_level)
                || (rsp_tdata[71:68] !== '0);
            if (bad) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp %0b %h %h %0d %0d, act %0b %h %h %0d %0d pad %h",
                           want.has_chunk, want.out_seq, want.out_payload, want.idle_count,
                           want.fill_level, rsp_tuser, rsp_tdata[31:0], rsp_tdata[47:32],
                           rsp_tdata[63:48], rsp_tdata[67:64], rsp_tdata[71:68]);
            end
         end
      end
   end

   // main sequence
   initial begin
      action_type          act;
      logic [SEQ_W-1:0]    seq;
      logic [SEQ_W-1:0]    base_seq;
      logic signed [31:0]  drift;
      int                  pick;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      for (int i = 0; i < DIRECTED_N; i++)
         send_request(DIRECTED[i].act, DIRECTED[i].seq, DIRECTED[i].pay,
                      DIRECTED[i].pinned, DIRECTED[i].want);

      // random playout traffic in four pacing phases: free running, sparse sender,
      // stalling receiver, light pressure on both sides
      base_seq = play_seq;
      for (int phase = 0; phase < 4; phase++) begin
         unique case (phase)
            0: begin send_gap_pct = 0;  stall_pct = 0;  end
            1: begin send_gap_pct = 87; stall_pct = 0;  end
            2: begin send_gap_pct = 0;  stall_pct = 87; end
            default: begin send_gap_pct = 16; stall_pct = 16; end
         endcase
         for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
            act = ($urandom_range(0, 99) < 50) ? ACT_PUSH : ACT_PULL;
            seq = $urandom();
            if (act == ACT_PUSH) begin
               // keep the stream near the playout point so chunks actually get delivered
               drift = base_seq - play_seq;
               if (drift > 64 || drift < -64)
                  base_seq = play_seq;
               pick = $urandom_range(0, 99);
               if (pick < 70) begin
                  seq = base_seq;           // in order
                  base_seq++;
               end else if (pick < 85) begin
                  seq = base_seq + $urandom_range(1, 3);   // early, arrives out of order
               end else if (pick < 95) begin
                  seq = base_seq - $urandom_range(1, 8);   // late or duplicate
               end
               // remaining share keeps the fully random number as noise
            end
            send_request(act, seq, CHUNK_PAY_W'($urandom()), 1'b0, '0);
         end
      end
      req_tvalid <= 1'b0;

      // drain, then give stray responses a chance to show up
      while (owed_wr != owed_rd)
         @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatches == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   // watchdog, far above the slowest legal run
   initial begin
      #30_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
